// File: hdl/olisr_pkg.sv
// Shared types for the ordered list block: request and status codes,
// and the command and status words between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package olisr_pkg;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_INS_FIRST = 2'd0,
        OP_INS_LAST  = 2'd1,
        OP_SEARCH    = 2'd2,
        OP_REMOVE    = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } t_status;

    // Walk index update
    typedef enum logic [2:0] {
        IDX_HOLD        = 3'd0,
        IDX_ZERO        = 3'd1,
        IDX_LAST        = 3'd2,
        IDX_AFTER_MATCH = 3'd3,
        IDX_INC         = 3'd4,
        IDX_DEC         = 3'd5
    } t_idx_op;

    // Memory write source
    typedef enum logic [2:0] {
        WR_NONE     = 3'd0,
        WR_VAL_HEAD = 3'd1,
        WR_VAL_TAIL = 3'd2,
        WR_UP       = 3'd3,
        WR_DN       = 3'd4
    } t_wr_op;

    // Result position source
    typedef enum logic [1:0] {
        POS_ZERO  = 2'd0,
        POS_LEN   = 2'd1,
        POS_RADDR = 2'd2,
        POS_MATCH = 2'd3
    } t_pos_sel;

    // Length update
    typedef enum logic [1:0] {
        LEN_HOLD = 2'd0,
        LEN_INC  = 2'd1,
        LEN_DEC  = 2'd2
    } t_len_op;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     rd;
        logic     match_cap;
        t_idx_op  idx_op;
        t_wr_op   wr_op;
        t_len_op  len_op;
        logic     res_load;
        t_status  res_status;
        logic     res_found;
        t_pos_sel pos_sel;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
        logic idx_zero;
        logic idx_end;
        logic rvalid;
    } t_stat;

endpackage

`default_nettype wire

// File: hdl/olisr_datapath.sv
// Datapath of the ordered list: entry memory, length, walk index,
// registered read with compare, and the result registers.
// Depends on olisr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module olisr_datapath
    import olisr_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic signed [31:0] i_value,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    output logic             [1:0]  o_status,
    output logic                    o_found,
    output logic             [3:0]  o_position,
    output logic             [4:0]  o_entry_count,
    output logic                    o_done
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam int PW = (LW > 4) ? LW : 4;
    localparam int CW = (LW > 5) ? LW : 5;

    logic [31:0]   r_mem [0:LIST_DEPTH-1];
    logic [31:0]   r_val;
    logic [31:0]   r_rdata;
    logic [AW-1:0] r_raddr;
    logic [AW-1:0] r_match;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_idx;
    logic          r_rvalid;
    logic [1:0]    r_status;
    logic          r_found;
    logic [3:0]    r_position;
    logic [4:0]    r_entry_count;
    logic          r_done;

    logic [LW-1:0] n_len;
    logic [LW-1:0] n_idx;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [PW-1:0] pos_w;
    logic [CW-1:0] cnt_w;
    logic          hit;

    // Compare the word read last cycle
    assign hit = r_rvalid && (r_rdata == r_val);

    // Next length
    always_comb begin
        case (i_cmd.len_op)
            LEN_HOLD: n_len = r_len;
            LEN_INC:  n_len = r_len + LW'(1);
            LEN_DEC:  n_len = r_len - LW'(1);
            default:  n_len = r_len;
        endcase
    end

    // Next walk index
    always_comb begin
        case (i_cmd.idx_op)
            IDX_HOLD:        n_idx = r_idx;
            IDX_ZERO:        n_idx = '0;
            IDX_LAST:        n_idx = r_len - LW'(1);
            IDX_AFTER_MATCH: n_idx = LW'(r_raddr) + LW'(1);
            IDX_INC:         n_idx = r_idx + LW'(1);
            IDX_DEC:         n_idx = r_idx - LW'(1);
            default:         n_idx = r_idx;
        endcase
    end

    // Select write address and data
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = r_val;
        case (i_cmd.wr_op)
            WR_NONE:     wr_en = 1'b0;
            WR_VAL_HEAD: wr_addr = '0;
            WR_VAL_TAIL: wr_addr = r_len[AW-1:0];
            WR_UP: begin
                wr_addr = r_raddr + AW'(1);
                wr_data = r_rdata;
            end
            WR_DN: begin
                wr_addr = r_raddr - AW'(1);
                wr_data = r_rdata;
            end
            default:     wr_en = 1'b0;
        endcase
    end

    // Result position and count, low bits kept
    always_comb begin
        case (i_cmd.pos_sel)
            POS_ZERO:  pos_w = '0;
            POS_LEN:   pos_w = PW'(r_len);
            POS_RADDR: pos_w = PW'(r_raddr);
            POS_MATCH: pos_w = PW'(r_match);
            default:   pos_w = '0;
        endcase
        cnt_w = CW'(n_len);
    end

    // Status toward the controller
    always_comb begin
        o_stat.full     = (r_len == LW'(LIST_DEPTH));
        o_stat.empty    = (r_len == '0);
        o_stat.hit      = hit;
        o_stat.idx_zero = (r_idx == '0);
        o_stat.idx_end  = (r_idx == r_len);
        o_stat.rvalid   = r_rvalid;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_idx    <= '0;
            r_rvalid <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_rvalid <= i_cmd.rd;
            r_done   <= i_cmd.res_load;
        end
    end

    // Entry memory with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_idx[AW-1:0]];
            r_raddr <= r_idx[AW-1:0];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // Capture request value, match index and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= i_value;
        end
        if (i_cmd.match_cap) begin
            r_match <= r_raddr;
        end
        if (i_cmd.res_load) begin
            r_status      <= i_cmd.res_status;
            r_found       <= i_cmd.res_found;
            r_position    <= pos_w[3:0];
            r_entry_count <= cnt_w[4:0];
        end
    end

    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_position    = r_position;
    assign o_entry_count = r_entry_count;
    assign o_done        = r_done;

    // Length stays within the memory
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(LIST_DEPTH))
        else $error("list length beyond depth");

    // Writes land inside the list or one past its end
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((LW + 1)'(wr_addr) <= (LW + 1)'(r_len)))
        else $error("write outside list");

    // Length changes only with a result
    a_len_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.len_op != LEN_HOLD) |-> i_cmd.res_load)
        else $error("length changed without result");

    // Shift writes need a word read the cycle before
    a_shift_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_op == WR_UP || i_cmd.wr_op == WR_DN) |-> r_rvalid)
        else $error("shift write without read data");

endmodule

`default_nettype wire

// File: hdl/olisr_ctrl.sv
// Controller of the ordered list: request decode and the walk sequences
// for search, remove (shift down) and insert-first (shift up).
// Depends on olisr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module olisr_ctrl
    import olisr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_opcode,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd,
    output logic            o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_HEAD,
        S_UP,
        S_UP_TAIL,
        S_SCAN,
        S_DROP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_remove;
    logic   n_remove;
    t_op    op;

    assign op     = t_op'(i_opcode);
    assign o_busy = (r_state != S_IDLE);

    // Decode state and status into datapath commands
    always_comb begin
        n_state          = r_state;
        n_remove         = r_remove;
        o_cmd.load       = 1'b0;
        o_cmd.rd         = 1'b0;
        o_cmd.match_cap  = 1'b0;
        o_cmd.idx_op     = IDX_HOLD;
        o_cmd.wr_op      = WR_NONE;
        o_cmd.len_op     = LEN_HOLD;
        o_cmd.res_load   = 1'b0;
        o_cmd.res_status = STAT_OK;
        o_cmd.res_found  = 1'b0;
        o_cmd.pos_sel    = POS_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_remove   = (op == OP_REMOVE);
                    case (op)
                        OP_INS_FIRST, OP_INS_LAST: begin
                            if (i_stat.full) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = STAT_FULL;
                            end else if (op == OP_INS_LAST) begin
                                n_state = S_APPEND;
                            end else if (i_stat.empty) begin
                                n_state = S_HEAD;
                            end else begin
                                o_cmd.idx_op = IDX_LAST;
                                n_state      = S_UP;
                            end
                        end
                        OP_SEARCH, OP_REMOVE: begin
                            if (i_stat.empty) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = STAT_EMPTY;
                            end else begin
                                o_cmd.idx_op = IDX_ZERO;
                                n_state      = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_APPEND: begin
                o_cmd.wr_op    = WR_VAL_TAIL;
                o_cmd.len_op   = LEN_INC;
                o_cmd.res_load = 1'b1;
                o_cmd.pos_sel  = POS_LEN;
                n_state        = S_IDLE;
            end
            // Move each word one place back, last entry first
            S_UP: begin
                o_cmd.rd = 1'b1;
                if (i_stat.rvalid) begin
                    o_cmd.wr_op = WR_UP;
                end
                if (i_stat.idx_zero) begin
                    n_state = S_UP_TAIL;
                end else begin
                    o_cmd.idx_op = IDX_DEC;
                end
            end
            S_UP_TAIL: begin
                o_cmd.wr_op = WR_UP;
                n_state     = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.wr_op    = WR_VAL_HEAD;
                o_cmd.len_op   = LEN_INC;
                o_cmd.res_load = 1'b1;
                o_cmd.pos_sel  = POS_ZERO;
                n_state        = S_IDLE;
            end
            // Read one word a cycle, compare it in the cycle after
            S_SCAN: begin
                if (i_stat.hit) begin
                    if (r_remove) begin
                        o_cmd.match_cap = 1'b1;
                        o_cmd.idx_op    = IDX_AFTER_MATCH;
                        n_state         = S_DROP;
                    end else begin
                        o_cmd.res_load  = 1'b1;
                        o_cmd.res_found = 1'b1;
                        o_cmd.pos_sel   = POS_RADDR;
                        n_state         = S_IDLE;
                    end
                end else if (i_stat.idx_end) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = STAT_NOT_FOUND;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.idx_op = IDX_INC;
                end
            end
            // Close the gap: move each later word one place forward
            S_DROP: begin
                if (i_stat.rvalid) begin
                    o_cmd.wr_op = WR_DN;
                end
                if (i_stat.idx_end) begin
                    o_cmd.len_op    = LEN_DEC;
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_found = 1'b1;
                    o_cmd.pos_sel   = POS_MATCH;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.idx_op = IDX_INC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the remove flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_remove <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_remove <= n_remove;
        end
    end

    // A result is issued only when the controller returns to idle
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> (n_state == S_IDLE))
        else $error("result issued while walk continues");

    // A read is never issued while a match is being taken
    a_no_rd_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_stat.hit) |-> !o_cmd.rd)
        else $error("read issued on a match");

    // Remove walk starts right after a match
    a_drop_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_stat.hit && r_remove) |=> (r_state == S_DROP))
        else $error("remove did not enter shift");

endmodule

`default_nettype wire

// File: hdl/ordered_list_insert_search_remove.sv
// Top level of the bounded ordered list of signed 32-bit values.
// Joins olisr_ctrl and olisr_datapath; depends on olisr_pkg.
//
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+------------------------------
//  request   | i_opcode, i_value                        | taken when start & !busy
//  result    | o_status, o_found, o_position,           | o_done high one cycle,
//            | o_entry_count                            | taken at that cycle's end
//
// A full-list insert or an empty-list search/remove is answered from idle;
// insert-last writes the tail without a walk, while insert-first, search and
// remove walk the list of n entries; the memory walk reads one word a cycle and
// writes the word read the cycle before.
// The result word appears in the cycle after the work ends, busy is low then.
// Reset (synchronous, active low) empties the list; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_search_remove
    import olisr_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [1:0]  i_opcode,
    input  wire logic signed [31:0] i_value,
    output logic                    o_done,
    output logic             [1:0]  o_status,
    output logic                    o_found,
    output logic             [3:0]  o_position,
    output logic             [4:0]  o_entry_count
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    olisr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Storage and result word
    olisr_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_entry_count (o_entry_count),
        .o_done        (o_done)
    );

    // An accepted word either starts a walk or returns at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted word neither busy nor answered");

    // A match is always reported with ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (o_status == STAT_OK))
        else $error("match reported with error status");

endmodule

`default_nettype wire
